[hdl/wsfs_pkg.sv]
// shared types, codes and constants of the ws2811 frame serializer
package wsfs_pkg;

  // op codes of an incoming word
  localparam logic [1:0] OP_TICK  = 2'd0;
  localparam logic [1:0] OP_WRITE = 2'd1;
  localparam logic [1:0] OP_START = 2'd2;

  // register indexes on the config port
  localparam logic [2:0] REG_ZERO_HIGH = 3'd0;
  localparam logic [2:0] REG_ZERO_LOW  = 3'd1;
  localparam logic [2:0] REG_ONE_HIGH  = 3'd2;
  localparam logic [2:0] REG_ONE_LOW   = 3'd3;
  localparam logic [2:0] REG_GAP       = 3'd4;
  localparam logic [2:0] REG_PIXELS    = 3'd5;

  localparam int ADDR_W = 5;
  localparam int DATA_W = 32;

  // register reset values
  localparam logic [7:0]  RST_ZERO_HIGH = 8'd5;
  localparam logic [7:0]  RST_ZERO_LOW  = 8'd20;
  localparam logic [7:0]  RST_ONE_HIGH  = 8'd12;
  localparam logic [7:0]  RST_ONE_LOW   = 8'd13;
  localparam logic [15:0] RST_GAP       = 16'd1400;
  localparam logic [6:0]  RST_PIXELS    = 7'd64;

  localparam int         WORD_W   = 24;
  localparam logic [4:0] BIT_LAST = 5'd23;

  // depth of the queue between front and back
  localparam int QDEPTH = 2;

  typedef enum logic [1:0] {
    K_TICK,
    K_WRITE,
    K_START,
    K_NOP
  } kind_t;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_HIGH,
    PH_LOW,
    PH_GAP
  } phase_t;

  typedef struct packed {
    kind_t             kind;
    logic [5:0]        pixel;
    logic [WORD_W-1:0] color;
  } q_item_t;

  typedef struct packed {
    logic [7:0]  zero_high;
    logic [7:0]  zero_low;
    logic [7:0]  one_high;
    logic [7:0]  one_low;
    logic [15:0] gap;
    logic [6:0]  pixels_in_use;
  } cfg_t;

  // zero duration counts as one tick
  function automatic logic [15:0] at_least_one8(input logic [7:0] v);
    return (v == 8'd0) ? 16'd1 : {8'd0, v};
  endfunction

endpackage

[hdl/wsfs_if.sv]
// handshake channels for input words and result words
interface wsfs_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  op;
  logic [5:0]  pixel;
  logic [23:0] color;

  modport source (output valid, op, pixel, color, input ready);
  modport sink (input valid, op, pixel, color, output ready);
endinterface

interface wsfs_out_if;
  logic valid;
  logic ready;
  logic line;
  logic busy_res;
  logic frame_done;

  modport source (output valid, line, busy_res, frame_done, input ready);
  modport sink (input valid, line, busy_res, frame_done, output ready);
endinterface

[hdl/wsfs_cfg.sv]
// apb register file holding the line timing and frame length
module wsfs_cfg (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [wsfs_pkg::ADDR_W-1:0] paddr,
  input  logic [wsfs_pkg::DATA_W-1:0] pwdata,
  output logic [wsfs_pkg::DATA_W-1:0] prdata,
  output logic                        pready,
  output wsfs_pkg::cfg_t              cfg
);
  import wsfs_pkg::*;

  logic       wr;
  logic [2:0] idx;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;
  assign idx    = paddr[ADDR_W-1:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.zero_high     <= RST_ZERO_HIGH;
      cfg.zero_low      <= RST_ZERO_LOW;
      cfg.one_high      <= RST_ONE_HIGH;
      cfg.one_low       <= RST_ONE_LOW;
      cfg.gap           <= RST_GAP;
      cfg.pixels_in_use <= RST_PIXELS;
    end else if (wr) begin
      case (idx)
        REG_ZERO_HIGH: cfg.zero_high     <= pwdata[7:0];
        REG_ZERO_LOW:  cfg.zero_low      <= pwdata[7:0];
        REG_ONE_HIGH:  cfg.one_high      <= pwdata[7:0];
        REG_ONE_LOW:   cfg.one_low       <= pwdata[7:0];
        REG_GAP:       cfg.gap           <= pwdata[15:0];
        REG_PIXELS:    cfg.pixels_in_use <= pwdata[6:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_ZERO_HIGH: prdata = {24'd0, cfg.zero_high};
      REG_ZERO_LOW:  prdata = {24'd0, cfg.zero_low};
      REG_ONE_HIGH:  prdata = {24'd0, cfg.one_high};
      REG_ONE_LOW:   prdata = {24'd0, cfg.one_low};
      REG_GAP:       prdata = {16'd0, cfg.gap};
      REG_PIXELS:    prdata = {25'd0, cfg.pixels_in_use};
      default:       prdata = '0;
    endcase
  end

endmodule

[hdl/wsfs_front.sv]
// front end: decodes incoming words and queues them for the line engine
module wsfs_front #(
  parameter int PIXELS = 64
) (
  input  logic              clk,
  input  logic              rst,
  wsfs_in_if.sink           item,
  input  logic              pop,
  output logic              head_valid,
  output wsfs_pkg::q_item_t head
);
  import wsfs_pkg::*;

  localparam int PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int CW = $clog2(QDEPTH + 1);

  q_item_t         q [QDEPTH];
  logic [PW-1:0]   wr_ptr;
  logic [PW-1:0]   rd_ptr;
  logic [CW-1:0]   count;
  kind_t           kind;
  logic            push;

  assign item.ready = (count != CW'(QDEPTH));
  assign push       = item.valid && item.ready;
  assign head_valid = (count != '0);
  assign head       = q[rd_ptr];

  // out of range writes and the unused op code become no-ops here
  always_comb begin
    case (item.op)
      OP_TICK:  kind = K_TICK;
      OP_WRITE: kind = (int'(item.pixel) < PIXELS) ? K_WRITE : K_NOP;
      OP_START: kind = K_START;
      default:  kind = K_NOP;
    endcase
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_ptr] <= '{kind: kind, pixel: item.pixel, color: item.color};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(QDEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(QDEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      case ({push, pop})
        2'b10:   count <= count + CW'(1);
        2'b01:   count <= count - CW'(1);
        default: ;
      endcase
    end
  end

  a_pop_needs_word: assert property (@(posedge clk) disable iff (rst)
    pop |-> head_valid)
    else $error("engine popped an empty queue");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(QDEPTH))
    else $error("queue count above depth");

  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    (count == CW'(QDEPTH)) |-> !push)
    else $error("word pushed into a full queue");

endmodule

[hdl/wsfs_back.sv]
// back end: frame store, bit timing engine and result register
module wsfs_back #(
  parameter int PIXELS = 64
) (
  input  logic              clk,
  input  logic              rst,
  input  wsfs_pkg::cfg_t    cfg,
  input  logic              head_valid,
  input  wsfs_pkg::q_item_t head,
  output logic              pop,
  wsfs_out_if.source        result
);
  import wsfs_pkg::*;

  localparam int AW = (PIXELS > 1) ? $clog2(PIXELS) : 1;

  logic [WORD_W-1:0] store [PIXELS];
  logic [WORD_W-1:0] rd_data;
  logic [AW-1:0]     rd_addr;
  logic [AW-1:0]     first_addr;
  logic [6:0]        n_raw;

  phase_t            phase, phase_next;
  logic [15:0]       tick_count, tick_next, tc_dec;
  logic [4:0]        bit_cursor, bit_next;
  logic [WORD_W-1:0] shift_word, shift_next;
  logic [AW-1:0]     pixel_cursor, pix_next;
  logic              line_q, line_next;
  logic              done_next;
  logic              mem_we;
  logic              start_wait;
  logic              stall_start;
  logic              out_free;

  logic [15:0] zh, zl, oh, ol, gp;

  logic res_valid, res_line, res_busy, res_done;

  assign zh = at_least_one8(cfg.zero_high);
  assign zl = at_least_one8(cfg.zero_low);
  assign oh = at_least_one8(cfg.one_high);
  assign ol = at_least_one8(cfg.one_low);
  assign gp = (cfg.gap == 16'd0) ? 16'd1 : cfg.gap;

  // highest pixel of the frame, clamped to the store
  assign n_raw = (cfg.pixels_in_use == 7'd0) ? 7'd1 : cfg.pixels_in_use;
  assign first_addr = (int'(n_raw) > PIXELS) ? AW'(PIXELS - 1) : AW'(n_raw - 7'd1);

  // read port looks one pixel ahead while busy, at the first pixel while idle
  assign rd_addr = (phase == PH_IDLE) ? first_addr : pixel_cursor - AW'(1);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      store[AW'(head.pixel)] <= head.color;
    end
    rd_data <= store[rd_addr];
  end

  assign out_free    = !res_valid || result.ready;
  assign stall_start = head_valid && (head.kind == K_START) && (phase == PH_IDLE)
                       && !start_wait;
  assign pop         = head_valid && out_free && !stall_start;
  assign tc_dec      = tick_count - 16'd1;

  always_comb begin
    phase_next = phase;
    tick_next  = tick_count;
    bit_next   = bit_cursor;
    shift_next = shift_word;
    pix_next   = pixel_cursor;
    line_next  = line_q;
    done_next  = 1'b0;
    mem_we     = 1'b0;
    if (pop) begin
      case (head.kind)
        K_WRITE: begin
          mem_we = (phase == PH_IDLE);
        end
        K_START: begin
          if (phase == PH_IDLE) begin
            pix_next   = first_addr;
            shift_next = rd_data;
            bit_next   = BIT_LAST;
            phase_next = PH_HIGH;
            tick_next  = rd_data[WORD_W-1] ? oh : zh;
          end
        end
        K_TICK: begin
          if (phase == PH_IDLE) begin
            line_next = 1'b0;
          end else begin
            line_next = (phase == PH_HIGH);
            tick_next = tc_dec;
            if (tc_dec == 16'd0) begin
              case (phase)
                PH_HIGH: begin
                  phase_next = PH_LOW;
                  tick_next  = shift_word[WORD_W-1] ? ol : zl;
                end
                PH_LOW: begin
                  if (bit_cursor != 5'd0) begin
                    bit_next   = bit_cursor - 5'd1;
                    shift_next = {shift_word[WORD_W-2:0], 1'b0};
                    phase_next = PH_HIGH;
                    tick_next  = shift_word[WORD_W-2] ? oh : zh;
                  end else if (pixel_cursor != '0) begin
                    pix_next   = pixel_cursor - AW'(1);
                    shift_next = rd_data;
                    bit_next   = BIT_LAST;
                    phase_next = PH_HIGH;
                    tick_next  = rd_data[WORD_W-1] ? oh : zh;
                  end else begin
                    phase_next = PH_GAP;
                    tick_next  = gp;
                  end
                end
                PH_GAP: begin
                  phase_next = PH_IDLE;
                  done_next  = 1'b1;
                end
                default: ;
              endcase
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_IDLE;
      tick_count   <= '0;
      bit_cursor   <= '0;
      shift_word   <= '0;
      pixel_cursor <= '0;
      line_q       <= 1'b0;
      start_wait   <= 1'b0;
      res_valid    <= 1'b0;
    end else begin
      phase        <= phase_next;
      tick_count   <= tick_next;
      bit_cursor   <= bit_next;
      shift_word   <= shift_next;
      pixel_cursor <= pix_next;
      line_q       <= line_next;
      start_wait   <= stall_start || (start_wait && !pop);
      if (pop) begin
        res_valid <= 1'b1;
      end else if (result.ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      res_line <= line_next;
      res_busy <= (phase_next != PH_IDLE);
      res_done <= done_next;
    end
  end

  assign result.valid      = res_valid;
  assign result.line       = res_line;
  assign result.busy_res   = res_busy;
  assign result.frame_done = res_done;

  a_count_live: assert property (@(posedge clk) disable iff (rst)
    (phase != PH_IDLE) |-> (tick_count != 16'd0))
    else $error("active period with empty tick count");

  a_start_after_read: assert property (@(posedge clk) disable iff (rst)
    (pop && head.kind == K_START && phase == PH_IDLE) |-> start_wait)
    else $error("frame started before store read settled");

  a_done_result: assert property (@(posedge clk) disable iff (rst)
    (pop && done_next) |=> (result.valid && result.frame_done && !result.busy_res))
    else $error("frame end not reported as idle done word");

endmodule

[hdl/ws2811_frame_serializer_top.sv]
// top level of the ws2811 frame serializer: config port, front end and line engine
// path: an accepted input word passes through the queue and then the result
//   register; a start word is held back until the registered store read has settled
// throughput: one word per cycle while the result register is free, set by the engine
//   step and the one-ahead store read port; a start is held back for the store read
// reset: synchronous rst clears the queue, engine state and registers; the frame
//   store is not cleared and holds nothing defined until written
module ws2811_frame_serializer_top #(
  parameter int PIXELS = 64
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [wsfs_pkg::ADDR_W-1:0] paddr,
  input  logic [wsfs_pkg::DATA_W-1:0] pwdata,
  output logic [wsfs_pkg::DATA_W-1:0] prdata,
  output logic                        pready,
  wsfs_in_if.sink                     item,
  wsfs_out_if.source                  result
);
  import wsfs_pkg::*;

  cfg_t    cfg;
  q_item_t head;
  logic    head_valid;
  logic    pop;

  // timing and frame length registers
  wsfs_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // front end: decode each word and park it in a two-entry queue, so input
  // acceptance does not wait on the result side until the queue is full
  wsfs_front #(
    .PIXELS (PIXELS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .item       (item),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head)
  );

  // back end: one queued word per cycle through the bit timing engine while the
  // output register is free and no start waits on the store read; the result is
  // held in an output register that takes a new word as the old one is taken
  wsfs_back #(
    .PIXELS (PIXELS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .result     (result)
  );

endmodule

[test/tb_top.sv]
// testbench for the ws2811 frame serializer: directed and random frames checked against a line model
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import wsfs_pkg::*;

  localparam int          N_PIXELS   = 64;
  localparam int          CYCLE_CAP  = 2_000_000;
  localparam int          DRAIN_IDLE = 6;
  localparam logic [1:0]  OP_NONE    = 2'd3;  // op code with no meaning, held as a no-op

  // one result word as the line model predicts it
  typedef struct packed {
    logic level;
    logic busy;
    logic done;
  } led_word_t;

  logic                clk;
  logic                rst;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [ADDR_W-1:0]   paddr;
  logic [DATA_W-1:0]   pwdata;
  logic [DATA_W-1:0]   prdata;
  logic                pready;

  wsfs_in_if  item_ch ();
  wsfs_out_if result_ch ();

  ws2811_frame_serializer_top #(
    .PIXELS(N_PIXELS)
  ) uut (
    .clk(clk),
    .rst(rst),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready),
    .item(item_ch),
    .result(result_ch)
  );

  // line model state: frame store, cursors, timer, driven level and a copy of the registers
  logic [WORD_W-1:0] store_mirror [N_PIXELS];
  bit                store_valid  [N_PIXELS];
  logic [5:0]        cur_pixel;
  logic [4:0]        cur_bit;
  logic [WORD_W-1:0] shift_reg;
  phase_t            ph;
  logic [15:0]       ticks_left;
  logic              line_lvl;
  cfg_t              regs;

  led_word_t pending_levels[$];  // predicted result words, oldest first
  int        effective_words;    // words that changed or advanced the model
  int        err_count;
  int        cycles;
  bit        no_idle;            // both sides run flat out while set

  // clock, 4 ns period
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // run cap: a hung handshake ends the run here
  initial begin
    cycles = 0;
    while (cycles < CYCLE_CAP) begin
      @(posedge clk);
      cycles++;
    end
    $display("RESULT: ERROR");
    $finish;
  end

  // result side: ready drops in about a quarter of the cycles unless the calm stretch is on
  initial begin
    result_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      result_ch.ready <= no_idle || ($urandom_range(0, 99) >= 25);
    end
  end

  // zero duration counts as one tick
  function automatic logic [15:0] ticks_of(input logic [15:0] v);
    return (v == 16'd0) ? 16'd1 : v;
  endfunction

  // pixels actually sent: 0 means 1, anything above the store depth is clamped
  function automatic int frame_pixels();
    int n;
    n = int'(regs.pixels_in_use);
    if (n == 0) n = 1;
    if (n > N_PIXELS) n = N_PIXELS;
    return n;
  endfunction

  // high half of a bit; duration depends on the bit now at the top of the shift register
  task automatic open_high();
    ph = PH_HIGH;
    ticks_left = ticks_of(shift_reg[WORD_W-1] ? {8'd0, regs.one_high} : {8'd0, regs.zero_high});
  endtask

  task automatic fetch_pixel(input logic [5:0] idx);
    cur_pixel = idx;
    shift_reg = store_mirror[idx];
    cur_bit   = BIT_LAST;
    open_high();
  endtask

  // advance the line model by one accepted word and queue the word it should produce
  task automatic step_line_model(input logic [1:0] op, input logic [5:0] px,
                                 input logic [WORD_W-1:0] col);
    led_word_t w;
    logic      fin;
    fin = 1'b0;
    case (op)
      OP_WRITE: begin
        // store writes only land while idle
        if (ph == PH_IDLE) begin
          store_mirror[px] = col;
          store_valid[px]  = 1'b1;
          effective_words++;
        end
      end
      OP_START: begin
        // start while busy is dropped
        if (ph == PH_IDLE) begin
          fetch_pixel(6'(frame_pixels() - 1));
          effective_words++;
        end
      end
      OP_TICK: begin
        if (ph == PH_IDLE) begin
          line_lvl = 1'b0;
        end else begin
          effective_words++;
          line_lvl   = (ph == PH_HIGH);
          ticks_left = ticks_left - 16'd1;
          if (ticks_left == 16'd0) begin
            case (ph)
              PH_HIGH: begin
                ph = PH_LOW;
                ticks_left = ticks_of(shift_reg[WORD_W-1] ? {8'd0, regs.one_low}
                                                          : {8'd0, regs.zero_low});
              end
              PH_LOW: begin
                if (cur_bit != 5'd0) begin
                  cur_bit   = cur_bit - 5'd1;
                  shift_reg = shift_reg << 1;
                  open_high();
                end else if (cur_pixel != 6'd0) begin
                  fetch_pixel(cur_pixel - 6'd1);
                end else begin
                  // last bit of pixel 0 done: latch gap follows
                  ph = PH_GAP;
                  ticks_left = ticks_of(regs.gap);
                end
              end
              default: begin
                // end of the latch gap
                ph  = PH_IDLE;
                fin = 1'b1;
              end
            endcase
          end
        end
      end
      default: ;  // unused op code: nothing moves, level held
    endcase
    w.level = line_lvl;
    w.busy  = (ph != PH_IDLE);
    w.done  = fin;
    pending_levels.push_back(w);
  endtask

  task automatic flag(input string msg);
    if (err_count < 10) $display("mismatch at cycle %0d: %s", cycles, msg);
    err_count++;
  endtask

  // result checker: every accepted result word against the oldest prediction
  always @(posedge clk) begin
    led_word_t want;
    if (!rst && result_ch.valid && result_ch.ready) begin
      if (pending_levels.size() == 0) begin
        flag("result word with nothing predicted");
      end else begin
        want = pending_levels.pop_front();
        if (result_ch.line !== want.level)
          flag($sformatf("line exp %b got %b", want.level, result_ch.line));
        if (result_ch.busy_res !== want.busy)
          flag($sformatf("busy_res exp %b got %b", want.busy, result_ch.busy_res));
        if (result_ch.frame_done !== want.done)
          flag($sformatf("frame_done exp %b got %b", want.done, result_ch.frame_done));
      end
    end
  end

  // send one word: random idle gaps ahead of it, then hold until accepted
  // valid is left high on return so back-to-back words need no extra step
  task automatic send_word(input logic [1:0] op, input logic [5:0] px,
                           input logic [WORD_W-1:0] col);
    if (!no_idle) begin
      while ($urandom_range(0, 99) < 25) begin
        item_ch.valid <= 1'b0;
        @(posedge clk);
      end
    end
    item_ch.valid <= 1'b1;
    item_ch.op    <= op;
    item_ch.pixel <= px;
    item_ch.color <= col;
    @(posedge clk);
    while (!item_ch.ready) @(posedge clk);
    step_line_model(op, px, col);
  endtask

  // tick word with junk in the unused fields
  task automatic send_tick();
    send_word(OP_TICK, 6'($urandom()), 24'($urandom()));
  endtask

  // stop sending and let every predicted result come back, plus the pipeline tail
  task automatic wait_drain();
    item_ch.valid <= 1'b0;
    while (pending_levels.size() != 0) @(posedge clk);
    repeat (DRAIN_IDLE) @(posedge clk);
  endtask

  // register write over apb; the frame is run out and the pipe drained first
  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    while (ph != PH_IDLE) send_tick();
    wait_drain();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_ZERO_HIGH: regs.zero_high     = val[7:0];
      REG_ZERO_LOW:  regs.zero_low      = val[7:0];
      REG_ONE_HIGH:  regs.one_high      = val[7:0];
      REG_ONE_LOW:   regs.one_low       = val[7:0];
      REG_GAP:       regs.gap           = val[15:0];
      REG_PIXELS:    regs.pixels_in_use = val[6:0];
      default: ;
    endcase
  endtask

  task automatic set_timing(input logic [31:0] zh, input logic [31:0] zl, input logic [31:0] oh,
                            input logic [31:0] ol, input logic [31:0] gap,
                            input logic [31:0] npix);
    write_reg(REG_ZERO_HIGH, zh);
    write_reg(REG_ZERO_LOW, zl);
    write_reg(REG_ONE_HIGH, oh);
    write_reg(REG_ONE_LOW, ol);
    write_reg(REG_GAP, gap);
    write_reg(REG_PIXELS, npix);
  endtask

  // one whole frame from idle; every pixel it sends is written first
  // noise_pct of the busy words are writes, starts or no-ops that must be dropped
  task automatic run_frame(input int noise_pct);
    logic [1:0] nop;
    for (int i = 0; i < frame_pixels(); i++)
      if (!store_valid[i]) send_word(OP_WRITE, 6'(i), 24'($urandom()));
    send_word(OP_START, 6'($urandom()), 24'($urandom()));
    while (ph != PH_IDLE) begin
      if ($urandom_range(0, 99) < noise_pct) begin
        case ($urandom_range(0, 2))
          0:       nop = OP_WRITE;
          1:       nop = OP_START;
          default: nop = OP_NONE;
        endcase
        send_word(nop, 6'($urandom()), 24'($urandom()));
      end else begin
        send_tick();
      end
    end
  endtask

  // idle block: ticks keep the line low, no-ops hold it, writes at both ends of the store
  task automatic test_idle_words();
    send_tick();
    send_word(OP_NONE, 6'd63, 24'hFFFFFF);
    send_word(OP_WRITE, 6'd0, 24'h000000);
    send_word(OP_WRITE, 6'd63, 24'hFFFFFF);
    send_word(OP_WRITE, 6'd0, 24'hA5C33C);
    send_word(OP_NONE, 6'd0, 24'h000000);
    send_tick();
  endtask

  // one pixel at the reset bit timing, with a short latch gap
  task automatic test_reset_timing();
    write_reg(REG_PIXELS, 32'd1);
    write_reg(REG_GAP, 32'd3);
    send_word(OP_WRITE, 6'd0, 24'h8001FF);
    run_frame(0);
  endtask

  // writes, starts and no-ops in the middle of a frame are dropped
  task automatic test_busy_words();
    set_timing(32'd1, 32'd1, 32'd2, 32'd1, 32'd2, 32'd2);
    send_word(OP_WRITE, 6'd1, 24'hF0F00F);
    run_frame(25);
    // store must still hold what was written before the frame
    run_frame(0);
  endtask

  // every register at zero: durations count as one, pixel count as one
  task automatic test_zero_registers();
    set_timing(32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0);
    send_word(OP_WRITE, 6'd0, 24'h5A5A5A);
    run_frame(0);
  endtask

  // longest high period of a one bit, followed by short zero bits
  task automatic test_slowest_bits();
    set_timing(32'd1, 32'd1, 32'd255, 32'd1, 32'd2, 32'd1);
    send_word(OP_WRITE, 6'd0, 24'h800000);
    run_frame(0);
  endtask

  // random small frames over several register settings; one setting with no idling
  task automatic test_random_frames();
    int base;
    for (int p = 0; p < 4; p++) begin
      no_idle = (p == 2);
      set_timing($urandom_range(0, 2), $urandom_range(0, 2), $urandom_range(0, 2),
                 $urandom_range(0, 2), $urandom_range(0, 4), $urandom_range(0, 3));
      base = effective_words;
      while (effective_words - base < 60) begin
        repeat ($urandom_range(0, 4))
          send_word(OP_WRITE, 6'($urandom()), 24'($urandom()));
        // stray idle ticks and no-ops between frames
        if ($urandom_range(0, 99) < 15)
          send_word($urandom_range(0, 1) ? OP_TICK : OP_NONE, 6'($urandom()), 24'($urandom()));
        // sender holds off until every result is back
        if ($urandom_range(0, 99) < 10) wait_drain();
        run_frame(5);
      end
    end
    no_idle = 1'b0;
  endtask

  // main sequence
  initial begin
    rst             <= 1'b1;
    psel            <= 1'b0;
    penable         <= 1'b0;
    pwrite          <= 1'b0;
    paddr           <= '0;
    pwdata          <= '0;
    item_ch.valid   <= 1'b0;
    item_ch.op      <= OP_TICK;
    item_ch.pixel   <= '0;
    item_ch.color   <= '0;
    err_count       = 0;
    effective_words = 0;
    no_idle         = 1'b0;
    // model after reset
    for (int i = 0; i < N_PIXELS; i++) begin
      store_mirror[i] = '0;
      store_valid[i]  = 1'b0;
    end
    cur_pixel          = '0;
    cur_bit            = '0;
    shift_reg          = '0;
    ph                 = PH_IDLE;
    ticks_left         = '0;
    line_lvl           = 1'b0;
    regs.zero_high     = RST_ZERO_HIGH;
    regs.zero_low      = RST_ZERO_LOW;
    regs.one_high      = RST_ONE_HIGH;
    regs.one_low       = RST_ONE_LOW;
    regs.gap           = RST_GAP;
    regs.pixels_in_use = RST_PIXELS;

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_idle_words();
    test_reset_timing();
    test_busy_words();
    test_zero_registers();
    test_slowest_bits();
    test_random_frames();

    // finish the last frame, then let the tail settle
    while (ph != PH_IDLE) send_tick();
    wait_drain();
    repeat (8) @(posedge clk);
    if (err_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
